// ----- rtl/velocity_pid_type_c_assert.svh -----
// Assertion macros for the velocity PID controller.
// Used by the top level; relies on clk_i and rst_ni in the including module.
`ifndef VELOCITY_PID_TYPE_C_ASSERT_SVH
`define VELOCITY_PID_TYPE_C_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/vpid_pkg.sv -----
// Package for the velocity PID controller: widths, register indexes and states.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package vpid_pkg;

  localparam int FRAC_BITS  = 16;

  localparam int T_W        = 16;
  localparam int KC_W       = 15;
  localparam int TI_W       = 16;
  localparam int TD_W       = 16;
  localparam int TS_W       = 8;
  localparam int LIM_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IG_W  = KC_W + TS_W + FRAC_BITS;
  localparam int DG_W  = KC_W + TD_W + FRAC_BITS;
  localparam int DV_W  = TI_W;
  localparam int DF_W  = T_W + 2;
  localparam int MAG_W = T_W + 1;
  localparam int SW    = DG_W + MAG_W + 3;
  localparam int CNT_W = $clog2(DG_W);

  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_TIME   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DERIVATIVE_TIME = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT     = CFG_IDX_W'(4);

  localparam logic FUNC_INIT = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_NEG,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic sub;
  } addsub_ctl_t;

endpackage

// ----- rtl/vpid_addsub.sv -----
// Shared adder and subtractor of the velocity PID controller.
// Serves the gain divider, the term multiplier and the final negation; uses vpid_pkg.
`timescale 1ns / 1ps

module vpid_addsub import vpid_pkg::*; (
  input  logic [SW-1:0] a_i,
  input  logic [SW-1:0] b_i,
  input  addsub_ctl_t   ctl_i,
  output logic [SW-1:0] y_o
);

  logic [SW-1:0] b_sel;

  assign b_sel = ctl_i.sub ? ~b_i : b_i;
  assign y_o   = a_i + b_sel + SW'(ctl_i.sub);

endmodule

// ----- rtl/velocity_pid_type_c.sv -----
// Top level of the velocity-form PID controller: sequencer, datapath and state.
// Uses vpid_pkg, vpid_addsub and the assertion macros in velocity_pid_type_c_assert.svh.
//
//   channel  direction  handshake                 beat contents
//   in       input      in_valid_i / in_stall_o   func, temperature, setpoint, enable
//   out      output     out_valid_o / out_stall_i drive
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// An init beat runs two restoring divisions of DG_W steps each through the shared adder.
// A step beat runs three shift-and-add products of MAG_W steps each; a step with
// enable clear skips them and goes straight to ST_FIN.
// Reset clears the control state and settings (drive limit 100), not the datapath.
// A result held by out_stall_i keeps the next beat in ST_FIN until it is taken.
`timescale 1ns / 1ps
`include "velocity_pid_type_c_assert.svh"

module velocity_pid_type_c import vpid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic signed [T_W-1:0] temperature_i,
  input  logic signed [T_W-1:0] setpoint_i,
  input  logic                  enable_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LIM_W-1:0]      drive_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;
  logic [1:0]       term_q, term_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  logic                  func_q, func_d;
  logic                  en_q, en_d;
  logic signed [T_W-1:0] y_q, y_d;
  logic signed [T_W-1:0] w_q, w_d;
  logic [SW-1:0]         acc_q, acc_d;
  logic [SW-1:0]         mcand_q, mcand_d;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [DG_W-1:0]       dvd_q, dvd_d;
  logic [DV_W-1:0]       rem_q, rem_d;
  logic                  sign_q, sign_d;
  logic [LIM_W-1:0]      out_drive_q, out_drive_d;

  logic [KC_W-1:0]  prop_gain_q;
  logic [TI_W-1:0]  integral_time_q;
  logic [TD_W-1:0]  derivative_time_q;
  logic [TS_W-1:0]  sample_period_q;
  logic [LIM_W-1:0] drive_limit_q;

  logic signed [T_W-1:0] prev_temp_q, prev_temp_d;
  logic signed [T_W-1:0] prev2_temp_q, prev2_temp_d;
  logic [LIM_W-1:0]      held_q, held_d;
  logic [IG_W-1:0]       int_gain_q, int_gain_d;
  logic [DG_W-1:0]       deriv_gain_q, deriv_gain_d;

  logic [SW-1:0] add_a, add_b, add_y;
  addsub_ctl_t   add_ctl;

  logic signed [DF_W-1:0] dif, neg_dif;
  logic [MAG_W-1:0]       ld_mag;
  logic [SW-1:0]          ld_gain;
  logic [DG_W-1:0]        ld_dvd;
  logic [DV_W-1:0]        divisor;
  logic [KC_W+TS_W-1:0]   prod_it;
  logic [KC_W+TD_W-1:0]   prod_dt;

  logic [DV_W:0]          trial;
  logic                   qbit;
  logic [SW-FRAC_BITS-1:0] quot;
  logic [T_W-1:0]         cap, inc_mag;
  logic signed [DF_W-1:0] inc, upd, lim_s;
  logic [LIM_W-1:0]       clamped;
  logic                   accept, out_busy;

  function automatic logic signed [DF_W-1:0] sx(input logic signed [T_W-1:0] v);
    return {{(DF_W-T_W){v[T_W-1]}}, v};
  endfunction

  vpid_addsub u_addsub (
    .a_i   (add_a),
    .b_i   (add_b),
    .ctl_i (add_ctl),
    .y_o   (add_y)
  );

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_busy    = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign drive_o     = out_drive_q;

  // Operand selection for the current term or division.
  always_comb begin
    prod_it = prop_gain_q * sample_period_q;
    prod_dt = prop_gain_q * derivative_time_q;
    case (term_q)
      2'd0: begin
        dif     = sx(prev_temp_q) - sx(y_q);
        ld_gain = SW'({prop_gain_q, {FRAC_BITS{1'b0}}});
        ld_dvd  = DG_W'({prod_it, {FRAC_BITS{1'b0}}});
        divisor = integral_time_q;
      end
      2'd1: begin
        dif     = sx(w_q) - sx(y_q);
        ld_gain = SW'(int_gain_q);
        ld_dvd  = DG_W'({prod_dt, {FRAC_BITS{1'b0}}});
        divisor = DV_W'(sample_period_q);
      end
      default: begin
        dif     = (sx(prev_temp_q) <<< 1) - sx(y_q) - sx(prev2_temp_q);
        ld_gain = SW'(deriv_gain_q);
        ld_dvd  = DG_W'({prod_dt, {FRAC_BITS{1'b0}}});
        divisor = DV_W'(sample_period_q);
      end
    endcase
    neg_dif = -dif;
    ld_mag  = dif[DF_W-1] ? neg_dif[MAG_W-1:0] : dif[MAG_W-1:0];
  end

  // Truncation, saturation and clamping of the new drive.
  always_comb begin
    quot    = acc_q[SW-1:FRAC_BITS];
    cap     = sign_q ? {1'b1, {(T_W-1){1'b0}}} : {1'b0, {(T_W-1){1'b1}}};
    inc_mag = (quot > (SW-FRAC_BITS)'(cap)) ? cap : quot[T_W-1:0];
    inc     = sign_q ? -$signed({2'b00, inc_mag}) : $signed({2'b00, inc_mag});
    upd     = $signed({{(DF_W-LIM_W){1'b0}}, held_q}) + inc;
    lim_s   = $signed({{(DF_W-LIM_W){1'b0}}, drive_limit_q});
    if (upd[DF_W-1]) begin
      clamped = '0;
    end else if (upd > lim_s) begin
      clamped = drive_limit_q;
    end else begin
      clamped = upd[LIM_W-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    term_d       = term_q;
    cnt_d        = cnt_q;
    func_d       = func_q;
    en_d         = en_q;
    y_d          = y_q;
    w_d          = w_q;
    acc_d        = acc_q;
    mcand_d      = mcand_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    sign_d       = sign_q;
    out_drive_d  = out_drive_q;
    prev_temp_d  = prev_temp_q;
    prev2_temp_d = prev2_temp_q;
    held_d       = held_q;
    int_gain_d   = int_gain_q;
    deriv_gain_d = deriv_gain_q;
    out_valid_d  = out_busy;
    trial        = {rem_q, dvd_q[DG_W-1]};
    qbit         = 1'b0;
    add_a        = acc_q;
    add_b        = mcand_q;
    add_ctl.sub  = neg_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d = func_i;
          en_d   = enable_i;
          y_d    = temperature_i;
          w_d    = setpoint_i;
          term_d = 2'd0;
          acc_d  = '0;
          if (func_i == FUNC_STEP && !enable_i) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (func_q == FUNC_INIT) begin
          dvd_d   = ld_dvd;
          rem_d   = '0;
          cnt_d   = CNT_W'(DG_W - 1);
          state_d = ST_DIV;
        end else begin
          mcand_d = ld_gain;
          mag_d   = ld_mag;
          neg_d   = dif[DF_W-1];
          cnt_d   = CNT_W'(MAG_W - 1);
          state_d = ST_MUL;
        end
      end
      ST_DIV: begin
        add_a       = SW'(trial);
        add_b       = SW'(divisor);
        add_ctl.sub = 1'b1;
        qbit        = !add_y[SW-1];
        rem_d       = qbit ? add_y[DV_W-1:0] : trial[DV_W-1:0];
        dvd_d       = {dvd_q[DG_W-2:0], qbit};
        cnt_d       = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          if (term_q == 2'd0) begin
            int_gain_d = (integral_time_q == '0) ? '0 : dvd_d[IG_W-1:0];
            term_d     = 2'd1;
            state_d    = ST_LOAD;
          end else begin
            deriv_gain_d = (sample_period_q == '0) ? '0 : dvd_d;
            state_d      = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        if (mag_q[0]) begin
          acc_d = add_y;
        end
        mcand_d = mcand_q << 1;
        mag_d   = mag_q >> 1;
        cnt_d   = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          if (term_q == 2'd2) begin
            state_d = ST_NEG;
          end else begin
            term_d  = term_q + 2'd1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_NEG: begin
        add_a       = '0;
        add_b       = acc_q;
        add_ctl.sub = 1'b1;
        sign_d      = acc_q[SW-1];
        if (acc_q[SW-1]) begin
          acc_d = add_y;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (func_q == FUNC_INIT) begin
            prev_temp_d  = y_q;
            prev2_temp_d = y_q;
            out_drive_d  = held_q;
          end else begin
            prev2_temp_d = prev_temp_q;
            prev_temp_d  = y_q;
            held_d       = en_q ? clamped : '0;
            out_drive_d  = en_q ? clamped : '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      prev_temp_q  <= '0;
      prev2_temp_q <= '0;
      held_q       <= '0;
      int_gain_q   <= '0;
      deriv_gain_q <= '0;
    end else begin
      term_q       <= term_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      prev_temp_q  <= prev_temp_d;
      prev2_temp_q <= prev2_temp_d;
      held_q       <= held_d;
      int_gain_q   <= int_gain_d;
      deriv_gain_q <= deriv_gain_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q       <= '0;
      integral_time_q   <= '0;
      derivative_time_q <= '0;
      sample_period_q   <= '0;
      drive_limit_q     <= LIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PROP_GAIN:       prop_gain_q       <= cfg_data_i[KC_W-1:0];
        CFG_INTEGRAL_TIME:   integral_time_q   <= cfg_data_i[TI_W-1:0];
        CFG_DERIVATIVE_TIME: derivative_time_q <= cfg_data_i[TD_W-1:0];
        CFG_SAMPLE_PERIOD:   sample_period_q   <= cfg_data_i[TS_W-1:0];
        CFG_DRIVE_LIMIT:     drive_limit_q     <= cfg_data_i[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    en_q        <= en_d;
    y_q         <= y_d;
    w_q         <= w_d;
    acc_q       <= acc_d;
    mcand_q     <= mcand_d;
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    sign_q      <= sign_d;
    out_drive_q <= out_drive_d;
  end

  `VPID_ASSERT_NXT(a_busy_after_accept, accept, in_stall_o, "Input not stalled after a beat")
  `VPID_ASSERT_IMP(a_div_on_init, state_q == ST_DIV, func_q == FUNC_INIT, "Division outside init")
  `VPID_ASSERT_IMP(a_mul_on_step, state_q == ST_MUL, func_q == FUNC_STEP && en_q, "Bad product")
  `VPID_ASSERT_IMP(a_result_from_fin, $rose(out_valid_o), $past(state_q == ST_FIN), "Stray result")

endmodule

// ----- tb/tb_velocity_pid_type_c.sv -----
// Self-checking testbench for the velocity-form type C PID controller.
// Depends on vpid_pkg and velocity_pid_type_c; predicts every drive beat and compares it.
`timescale 1ns / 1ps

module tb_velocity_pid_type_c;
  import vpid_pkg::*;

  typedef struct {
    logic                  func;
    logic signed [T_W-1:0] temp;
    logic signed [T_W-1:0] setp;
    logic                  enable;
  } pid_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  func_i = FUNC_INIT;
  logic signed [T_W-1:0] temperature_i = '0;
  logic signed [T_W-1:0] setpoint_i = '0;
  logic                  enable_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [LIM_W-1:0]      drive_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_PROP_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [KC_W-1:0]  prop_gain_q = '0;
  logic [TI_W-1:0]  integral_time_q = '0;
  logic [TD_W-1:0]  derivative_time_q = '0;
  logic [TS_W-1:0]  sample_period_q = '0;
  logic [LIM_W-1:0] drive_limit_q = LIM_RESET;
  logic [63:0]      int_gain_q = '0;
  logic [63:0]      deriv_gain_q = '0;
  int               last_temp = 0;
  int               older_temp = 0;
  int               drive_held = 0;

  pid_beat_t        beats_to_send[$];
  pid_beat_t        beat_cur;
  logic [LIM_W-1:0] drive_expected[$];
  logic [LIM_W-1:0] drive_want;
  int               send_gap = 0;
  int               stall_left = 0;
  int               stall_pick;
  int               error_count = 0;
  int               beats_planned = 0;
  bit               quiet_idle = 1'b0;

  velocity_pid_type_c i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .temperature_i(temperature_i),
    .setpoint_i   (setpoint_i),
    .enable_i     (enable_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_o      (drive_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic flag_error(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_idle || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [LIM_W-1:0] predict_drive(pid_beat_t b);
    logic signed [127:0] sum, mag, quo, gp, gi, gd, dp, di, dd;
    logic                neg;
    int                  y, w, u, inc;
    y = b.temp;
    w = b.setp;
    if (b.func == FUNC_INIT) begin
      int_gain_q = (integral_time_q == 0) ? 64'd0
                 : ((64'(prop_gain_q) * sample_period_q) << FRAC_BITS) / integral_time_q;
      deriv_gain_q = (sample_period_q == 0) ? 64'd0
                   : ((64'(prop_gain_q) * derivative_time_q) << FRAC_BITS) / sample_period_q;
      last_temp = y;
      older_temp = y;
    end else begin
      if (b.enable) begin
        gp = 128'(prop_gain_q) << FRAC_BITS;
        gi = 128'(int_gain_q);
        gd = 128'(deriv_gain_q);
        dp = last_temp - y;
        di = w - y;
        dd = 2 * last_temp - y - older_temp;
        sum = gp * dp + gi * di + gd * dd;
        neg = sum < 0;
        mag = neg ? -sum : sum;
        quo = mag >>> FRAC_BITS;
        if (quo > (neg ? 32768 : 32767)) quo = neg ? 32768 : 32767;
        inc = neg ? -int'(quo) : int'(quo);
        u = drive_held + inc;
        if (u > int'(drive_limit_q)) u = int'(drive_limit_q);
        else if (u < 0) u = 0;
        drive_held = u;
      end else begin
        drive_held = 0;
      end
      older_temp = last_temp;
      last_temp = y;
    end
    return LIM_W'(drive_held);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        drive_expected.push_back(predict_drive(beat_cur));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          beat_cur = beats_to_send.pop_front();
          func_i <= beat_cur.func;
          temperature_i <= beat_cur.temp;
          setpoint_i <= beat_cur.setp;
          enable_i <= beat_cur.enable;
          in_valid_i <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (drive_expected.size() == 0) begin
          flag_error($sformatf("drive beat %0d arrived with nothing expected", drive_o));
        end else begin
          drive_want = drive_expected.pop_front();
          if (drive_o !== drive_want) begin
            flag_error($sformatf("drive %0d, expected %0d", drive_o, drive_want));
          end
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        stall_pick = pick_gap();
        out_stall_i <= (stall_pick != 0);
        stall_left <= (stall_pick == 0) ? 0 : stall_pick - 1;
      end
    end
  end

  task automatic push_beat(logic f, int t, int s, logic en);
    pid_beat_t b;
    b.func = f;
    b.temp = T_W'(t);
    b.setp = T_W'(s);
    b.enable = en;
    beats_to_send.push_back(b);
    beats_planned++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    case (idx)
      CFG_PROP_GAIN:       prop_gain_q = KC_W'(val);
      CFG_INTEGRAL_TIME:   integral_time_q = TI_W'(val);
      CFG_DERIVATIVE_TIME: derivative_time_q = TD_W'(val);
      CFG_SAMPLE_PERIOD:   sample_period_q = TS_W'(val);
      CFG_DRIVE_LIMIT:     drive_limit_q = LIM_W'(val);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (beats_to_send.size() != 0 || in_valid_i || drive_expected.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int          r, n_items, temp, setp;
    bit          noisy;
    int unsigned kc, ti, td, ts, lim;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the reset settings every gain is zero and the drive stays at rest.
    push_beat(FUNC_STEP, 10, 20, 1'b1);
    push_beat(FUNC_INIT, 0, 0, 1'b0);
    wait_idle();

    write_reg(CFG_PROP_GAIN, 4);
    write_reg(CFG_INTEGRAL_TIME, 10);
    write_reg(CFG_DERIVATIVE_TIME, 3);
    write_reg(CFG_SAMPLE_PERIOD, 2);
    write_reg(CFG_DRIVE_LIMIT, 100);
    push_beat(FUNC_INIT, 100, 0, 1'b1);
    push_beat(FUNC_STEP, 95, 120, 1'b1);
    push_beat(FUNC_STEP, 90, 120, 1'b1);
    push_beat(FUNC_STEP, 92, 120, 1'b1);
    push_beat(FUNC_STEP, 93, 120, 1'b0);
    push_beat(FUNC_STEP, -32768, 32767, 1'b1);
    push_beat(FUNC_STEP, 32767, -32768, 1'b1);
    push_beat(FUNC_INIT, -5, 7, 1'b1);
    wait_idle();

    // New gains without an init beat: only the proportional term follows them.
    write_reg(CFG_PROP_GAIN, 20);
    write_reg(CFG_INTEGRAL_TIME, 0);
    push_beat(FUNC_STEP, -20, 40, 1'b1);
    push_beat(FUNC_STEP, -30, 40, 1'b1);
    wait_idle();

    write_reg(CFG_PROP_GAIN, 32767);
    write_reg(CFG_INTEGRAL_TIME, 1);
    write_reg(CFG_DERIVATIVE_TIME, 65535);
    write_reg(CFG_SAMPLE_PERIOD, 255);
    write_reg(CFG_DRIVE_LIMIT, 32767);
    push_beat(FUNC_INIT, -32768, 0, 1'b1);
    push_beat(FUNC_STEP, 32767, 32767, 1'b1);
    push_beat(FUNC_STEP, -32768, -32768, 1'b1);
    push_beat(FUNC_STEP, 32767, -32768, 1'b1);
    push_beat(FUNC_STEP, 0, 0, 1'b1);
    wait_idle();

    write_reg(CFG_PROP_GAIN, 1);
    write_reg(CFG_INTEGRAL_TIME, 65535);
    write_reg(CFG_DERIVATIVE_TIME, 0);
    write_reg(CFG_SAMPLE_PERIOD, 0);
    write_reg(CFG_DRIVE_LIMIT, 0);
    push_beat(FUNC_INIT, 1, 0, 1'b1);
    push_beat(FUNC_STEP, -1, 5, 1'b1);
    push_beat(FUNC_STEP, 0, 0, 1'b1);
    wait_idle();

    while (beats_planned < 1650) begin
      quiet_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      kc = (r == 0) ? 0 : (r == 1) ? 32767 : $urandom_range(1, 60);
      r = $urandom_range(0, 11);
      ti = (r < 2) ? 0 : (r == 2) ? 65535 : $urandom_range(1, 600);
      r = $urandom_range(0, 7);
      td = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1, 200);
      r = $urandom_range(0, 9);
      ts = (r < 2) ? 0 : (r == 2) ? 255 : $urandom_range(1, 10);
      r = $urandom_range(0, 9);
      lim = (r < 2) ? 100 : (r == 2) ? 0 : (r == 3) ? 32767 : $urandom_range(1, 32767);
      write_reg(CFG_PROP_GAIN, kc);
      write_reg(CFG_INTEGRAL_TIME, ti);
      write_reg(CFG_DERIVATIVE_TIME, td);
      write_reg(CFG_SAMPLE_PERIOD, ts);
      write_reg(CFG_DRIVE_LIMIT, lim);

      noisy = ($urandom_range(0, 4) == 0);
      n_items = $urandom_range(60, 140);
      setp = int'($urandom_range(0, 60000)) - 30000;
      temp = setp + int'($urandom_range(0, 400)) - 200;
      if ($urandom_range(0, 4) != 0) push_beat(FUNC_INIT, temp, setp, 1'b1);
      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        if (noisy || r < 4) begin
          push_beat(logic'($urandom_range(0, 1)), int'($urandom_range(0, 65535)),
                    int'($urandom_range(0, 65535)), logic'($urandom_range(0, 1)));
        end else if (r < 7) begin
          push_beat(FUNC_INIT, temp, setp, 1'b1);
        end else begin
          if (r < 9) setp = int'($urandom_range(0, 60000)) - 30000;
          temp = temp + int'($urandom_range(0, 20)) - 10;
          if (temp > 32767) temp = 32767;
          if (temp < -32768) temp = -32768;
          push_beat(FUNC_STEP, temp, setp, ($urandom_range(0, 29) != 0));
        end
      end
      wait_idle();
    end

    quiet_idle = 1'b0;
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Timeout: the controller stopped answering.");
    $display("Test completed with failures");
    $finish;
  end

endmodule
